/* sv/c2dzp_pkg.sv */
// Package for the zero-padded 2D convolution stream: shared types and constants.
// Used by front, back, top level and testbench; depends on nothing.
package c2dzp_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 16;
    localparam int KROW_W     = 48;
    localparam int WIN        = 3;
    localparam int ROW_W      = 13;
    localparam int OUT_ROW_W  = 12;
    localparam int HEIGHT_MAX = 4096;
    localparam int COL_W      = 12;
    localparam int PROD_W     = 25;
    localparam int RSUM_W     = 27;
    localparam int OUT_W      = 28;
    localparam int CFG_IDX_W  = 3;
    localparam int WQ_DEPTH   = 4;
    localparam int OQ_DEPTH   = 8;
    localparam int OQ_CNT_W   = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_KERNEL_WIDTH  = 3'd2,
        REG_KERNEL_HEIGHT = 3'd3,
        REG_KROW_TOP      = 3'd4,
        REG_KROW_MID      = 3'd5,
        REG_KROW_BOT      = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [10:0] image_width;
        logic [12:0] image_height;
        logic [1:0]  kernel_width;
        logic [1:0]  kernel_height;
    } geom_t;

    typedef struct packed {
        logic [PIX_W-1:0]   px;
        logic [COL_W-1:0]   col;
        logic [WIN*WIN-1:0] mask;
        logic               emit;
        logic               last;
    } work_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic                    frame_end;
    } result_t;

endpackage

/* sv/c2dzp_fifo.sv */
// Small register queue used between the front, the back and the result port.
// Depends on nothing; DEPTH must be a power of two.
module c2dzp_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [W-1:0]               wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [W-1:0]               rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH+1);

    logic [W-1:0]   store_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CNW-1:0] cnt_reg;
    logic [CNW-1:0] cnt_next;
    logic           push_ok;
    logic           pop_ok;

    assign full    = (cnt_reg == CNW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign count   = cnt_reg;
    assign rdata   = store_reg[rd_ptr_reg];
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok && !pop_ok)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/c2dzp_front.sv */
// Front of the convolution stream: accepts items, tracks frame positions and
// turns unskipped items into work records for the back. Depends on c2dzp_pkg.
module c2dzp_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int KERNEL_MAX = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic                    full,
    input  logic                    action,
    input  logic [7:0]              pixel,
    input  c2dzp_pkg::geom_t        geom,
    input  logic                    restart,
    output logic                    work_push,
    output c2dzp_pkg::work_t        work
);

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int LW = WW + 1;

    logic [WW-1:0]                       w;
    logic [c2dzp_pkg::ROW_W-1:0]         h;
    logic [1:0]                          kw;
    logic [1:0]                          kh;
    logic                                cx;
    logic                                cy;
    logic [LW-1:0]                       lag;
    logic                                accept;
    logic                                drain;
    logic                                skip;
    logic                                emit;
    logic                                last;
    logic                                col_wrap;
    logic                                out_wrap;
    logic [c2dzp_pkg::WIN-1:0]           row_ok;
    logic [c2dzp_pkg::WIN-1:0]           col_ok;
    logic [c2dzp_pkg::WIN*c2dzp_pkg::WIN-1:0] mask;

    logic [c2dzp_pkg::ROW_W-1:0]     in_row_reg;
    logic [c2dzp_pkg::ROW_W-1:0]     in_row_next;
    logic [CW-1:0]                   in_col_reg;
    logic [CW-1:0]                   in_col_next;
    logic [c2dzp_pkg::OUT_ROW_W-1:0] out_row_reg;
    logic [c2dzp_pkg::OUT_ROW_W-1:0] out_row_next;
    logic [CW-1:0]                   out_col_reg;
    logic [CW-1:0]                   out_col_next;
    logic [LW-1:0]                   pos_cnt_reg;
    logic [LW-1:0]                   pos_cnt_next;

    always_comb
    begin
        if (geom.image_width == '0)
        begin
            w = WW'(1);
        end
        else if (32'(geom.image_width) > MAX_WIDTH)
        begin
            w = WW'(MAX_WIDTH);
        end
        else
        begin
            w = WW'(geom.image_width);
        end

        if (geom.image_height == '0)
        begin
            h = c2dzp_pkg::ROW_W'(1);
        end
        else if (32'(geom.image_height) > c2dzp_pkg::HEIGHT_MAX)
        begin
            h = c2dzp_pkg::ROW_W'(c2dzp_pkg::HEIGHT_MAX);
        end
        else
        begin
            h = geom.image_height;
        end

        if (geom.kernel_width == '0)
        begin
            kw = 2'd1;
        end
        else if (32'(geom.kernel_width) > KERNEL_MAX)
        begin
            kw = 2'(KERNEL_MAX);
        end
        else
        begin
            kw = geom.kernel_width;
        end

        if (geom.kernel_height == '0)
        begin
            kh = 2'd1;
        end
        else if (32'(geom.kernel_height) > KERNEL_MAX)
        begin
            kh = 2'(KERNEL_MAX);
        end
        else
        begin
            kh = geom.kernel_height;
        end

        cx  = kw[1];
        cy  = kh[1];
        lag = cy ? (LW'(w) + LW'(cx)) : LW'(cx);
    end

    always_comb
    begin
        for (int m = 0; m < c2dzp_pkg::WIN; m++)
        begin
            row_ok[m] = (32'(m) < 32'(kh))
                     && (32'(out_row_reg) + 32'(cy) >= 32'(m))
                     && (32'(out_row_reg) + 32'(cy) - 32'(m) < 32'(h));
            col_ok[m] = (32'(m) < 32'(kw))
                     && (32'(out_col_reg) + 32'(cx) >= 32'(m))
                     && (32'(out_col_reg) + 32'(cx) - 32'(m) < 32'(w));
        end
        for (int m = 0; m < c2dzp_pkg::WIN; m++)
        begin
            for (int n = 0; n < c2dzp_pkg::WIN; n++)
            begin
                mask[m*c2dzp_pkg::WIN + n] = row_ok[m] && col_ok[n];
            end
        end
    end

    assign accept    = push && !full;
    assign drain     = (in_row_reg >= h);
    assign skip      = !drain && action;
    assign emit      = (pos_cnt_reg == lag);
    assign last      = (32'(out_row_reg) + 32'd1 == 32'(h))
                    && (32'(out_col_reg) + 32'd1 == 32'(w));
    assign col_wrap  = (32'(in_col_reg) + 32'd1 >= 32'(w));
    assign out_wrap  = (32'(out_col_reg) + 32'd1 >= 32'(w));
    assign work_push = accept && !skip;

    always_comb
    begin
        work.px   = drain ? '0 : pixel;
        work.col  = c2dzp_pkg::COL_W'(in_col_reg);
        work.mask = mask;
        work.emit = emit;
        work.last = emit && last;
    end

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        pos_cnt_next = pos_cnt_reg;
        if (restart || (work_push && emit && last))
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
            pos_cnt_next = '0;
        end
        else if (work_push)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (emit)
            begin
                if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
            else
            begin
                pos_cnt_next = pos_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            pos_cnt_reg <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            pos_cnt_reg <= pos_cnt_next;
        end
    end

    a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_cnt_reg <= lag)
        else $error("Position counter ran past the output lag.");

    a_out_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(out_row_reg) < 32'(h))
        else $error("Output row left the frame.");

endmodule

/* sv/c2dzp_back.sv */
// Back of the convolution stream: line store, 3x3 window and the multiply-add
// pipeline that produces one result per emitting record. Depends on c2dzp_pkg.
module c2dzp_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  c2dzp_pkg::work_t                                    work,
    input  logic                                                work_empty,
    output logic                                                work_pop,
    input  logic [c2dzp_pkg::WIN-1:0][c2dzp_pkg::KROW_W-1:0]    krows,
    input  logic [c2dzp_pkg::OQ_CNT_W-1:0]                      out_count,
    output logic                                                res_push,
    output c2dzp_pkg::result_t                                  res
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CRW = c2dzp_pkg::OQ_CNT_W + 1;
    localparam int PW  = c2dzp_pkg::PIX_W;
    localparam int NW  = c2dzp_pkg::WIN;

    logic [2*PW-1:0] line_mem [MAX_WIDTH];

    logic                     s1_v_reg;
    c2dzp_pkg::work_t         s1_reg;
    logic [2*PW-1:0]          rd_reg;
    logic                     byp_v_reg;
    logic [2*PW-1:0]          byp_data_reg;
    logic [2*PW-1:0]          line_old;
    logic [2*PW-1:0]          line_new;

    logic [PW-1:0]            win_reg  [NW][NW];
    logic [PW-1:0]            win_next [NW][NW];

    logic                     s2_v_reg;
    logic [NW*NW-1:0]         s2_mask_reg;
    logic                     s2_last_reg;

    logic signed [c2dzp_pkg::COEF_W-1:0] coef [NW][NW];
    logic signed [c2dzp_pkg::PROD_W-1:0] prod_next [NW][NW];
    logic signed [c2dzp_pkg::PROD_W-1:0] prod_reg  [NW][NW];
    logic                                s3_v_reg;
    logic                                s3_last_reg;

    logic signed [c2dzp_pkg::RSUM_W-1:0] rsum_next [NW];
    logic signed [c2dzp_pkg::RSUM_W-1:0] rsum_reg  [NW];
    logic                                s4_v_reg;
    logic                                s4_last_reg;

    logic [2:0]               inflight;
    logic                     credit_ok;
    logic [AW-1:0]            rd_addr;
    logic [AW-1:0]            wr_addr;

    assign inflight  = 3'(s1_v_reg && s1_reg.emit) + 3'(s2_v_reg) + 3'(s3_v_reg)
                     + 3'(s4_v_reg);
    assign credit_ok = (CRW'(out_count) + CRW'(inflight)) < CRW'(c2dzp_pkg::OQ_DEPTH);
    assign work_pop  = !work_empty && credit_ok;
    assign rd_addr   = work.col[AW-1:0];
    assign wr_addr   = s1_reg.col[AW-1:0];

    assign line_old  = byp_v_reg ? byp_data_reg : rd_reg;
    assign line_new  = {line_old[PW-1:0], s1_reg.px};

    always_comb
    begin
        for (int m = 0; m < NW; m++)
        begin
            win_next[m][2] = win_reg[m][1];
            win_next[m][1] = win_reg[m][0];
        end
        win_next[0][0] = s1_reg.px;
        win_next[1][0] = line_old[PW-1:0];
        win_next[2][0] = line_old[2*PW-1:PW];
    end

    always_comb
    begin
        for (int m = 0; m < NW; m++)
        begin
            for (int n = 0; n < NW; n++)
            begin
                coef[m][n] = $signed(krows[m][16*n +: c2dzp_pkg::COEF_W]);
                if (s2_mask_reg[m*NW + n])
                begin
                    prod_next[m][n] = $signed({1'b0, win_reg[m][n]}) * coef[m][n];
                end
                else
                begin
                    prod_next[m][n] = '0;
                end
            end
        end
        for (int m = 0; m < NW; m++)
        begin
            rsum_next[m] = c2dzp_pkg::RSUM_W'(prod_reg[m][0])
                         + c2dzp_pkg::RSUM_W'(prod_reg[m][1])
                         + c2dzp_pkg::RSUM_W'(prod_reg[m][2]);
        end
    end

    always_comb
    begin
        res_push        = s4_v_reg;
        res.value       = c2dzp_pkg::OUT_W'(rsum_reg[0]) + c2dzp_pkg::OUT_W'(rsum_reg[1])
                        + c2dzp_pkg::OUT_W'(rsum_reg[2]);
        res.frame_end   = s4_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            rd_reg <= line_mem[rd_addr];
        end
        if (s1_v_reg)
        begin
            line_mem[wr_addr] <= line_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            s1_reg       <= work;
            byp_data_reg <= line_new;
        end
        s2_mask_reg <= s1_reg.mask;
        s2_last_reg <= s1_reg.last;
        prod_reg    <= prod_next;
        s3_last_reg <= s2_last_reg;
        rsum_reg    <= rsum_next;
        s4_last_reg <= s3_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            byp_v_reg <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            for (int m = 0; m < NW; m++)
            begin
                for (int n = 0; n < NW; n++)
                begin
                    win_reg[m][n] <= '0;
                end
            end
        end
        else
        begin
            s1_v_reg <= work_pop;
            if (work_pop)
            begin
                byp_v_reg <= s1_v_reg && (s1_reg.col == work.col);
            end
            s2_v_reg <= s1_v_reg && s1_reg.emit;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            if (s1_v_reg)
            begin
                win_reg <= win_next;
            end
        end
    end

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (CRW'(out_count) + CRW'(inflight)) <= CRW'(c2dzp_pkg::OQ_DEPTH))
        else $error("Results in flight exceed the space of the result queue.");

endmodule

/* sv/conv2d_zero_padded_stream.sv */
// Top level of the zero-padded same-size 2D convolution stream.
// Holds the configuration registers and joins front, work queue, back and
// result queue. Depends on c2dzp_pkg, c2dzp_fifo, c2dzp_front and c2dzp_back.
//
// Input side: an item (action, pixel) is a transaction when push is high and
// full is low. Pixels arrive in raster order; flush items after the last
// pixel drain the tail, one result each. Result side: while empty is low the
// oldest result (out_value, frame_end) is on the ports, and a transaction
// completes when pop is high. Configuration: cfg_index and cfg_data are
// written when cfg_valid and cfg_ready are high; cfg_ready is always high.
// Writes to geometry registers restart the frame position.
// Throughput is one item per cycle while full is low. After the transaction
// of the item that completes it, a result is registered in the work queue,
// which ends with the line store read, then in the window and the products,
// in the row sums and, as the final sum of the three rows, in the result
// queue. The line store is read at one address and written at one address
// each cycle. When pop stays low, the result queue of eight entries fills,
// the back stops taking work, the work queue of four fills and full rises.
// Reset clears positions, window and queues; the line store holds no reset
// value and needs no clearing pass.
module conv2d_zero_padded_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int KERNEL_MAX = 3
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     push,
    output logic                                     full,
    input  logic                                     action,
    input  logic [7:0]                               pixel,
    output logic                                     empty,
    input  logic                                     pop,
    output logic signed [c2dzp_pkg::OUT_W-1:0]       out_value,
    output logic                                     frame_end,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [c2dzp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [c2dzp_pkg::KROW_W-1:0]             cfg_data
);

    localparam int WORK_W = $bits(c2dzp_pkg::work_t);
    localparam int RES_W  = $bits(c2dzp_pkg::result_t);

    c2dzp_pkg::geom_t  geom_reg;
    c2dzp_pkg::geom_t  geom_next;
    logic [c2dzp_pkg::WIN-1:0][c2dzp_pkg::KROW_W-1:0] krows_reg;
    logic [c2dzp_pkg::WIN-1:0][c2dzp_pkg::KROW_W-1:0] krows_next;
    logic              cfg_we;
    logic              restart;

    logic              work_push;
    c2dzp_pkg::work_t  work_in;
    c2dzp_pkg::work_t  work_head;
    logic              work_full;
    logic              work_empty;
    logic              work_pop;
    logic [$clog2(c2dzp_pkg::WQ_DEPTH+1)-1:0] work_count;

    logic                           res_push;
    c2dzp_pkg::result_t             res_in;
    c2dzp_pkg::result_t             res_head;
    logic                           res_full;
    logic [c2dzp_pkg::OQ_CNT_W-1:0] res_count;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        geom_next  = geom_reg;
        krows_next = krows_reg;
        restart    = 1'b0;
        if (cfg_we)
        begin
            case (c2dzp_pkg::reg_idx_t'(cfg_index))
                c2dzp_pkg::REG_IMAGE_WIDTH:
                begin
                    geom_next.image_width = cfg_data[10:0];
                    restart = 1'b1;
                end
                c2dzp_pkg::REG_IMAGE_HEIGHT:
                begin
                    geom_next.image_height = cfg_data[12:0];
                    restart = 1'b1;
                end
                c2dzp_pkg::REG_KERNEL_WIDTH:
                begin
                    geom_next.kernel_width = cfg_data[1:0];
                    restart = 1'b1;
                end
                c2dzp_pkg::REG_KERNEL_HEIGHT:
                begin
                    geom_next.kernel_height = cfg_data[1:0];
                    restart = 1'b1;
                end
                c2dzp_pkg::REG_KROW_TOP:
                begin
                    krows_next[0] = cfg_data;
                end
                c2dzp_pkg::REG_KROW_MID:
                begin
                    krows_next[1] = cfg_data;
                end
                c2dzp_pkg::REG_KROW_BOT:
                begin
                    krows_next[2] = cfg_data;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.image_width   <= 11'd640;
            geom_reg.image_height  <= 13'd480;
            geom_reg.kernel_width  <= 2'd3;
            geom_reg.kernel_height <= 2'd3;
            krows_reg[0]           <= 48'd0;
            krows_reg[1]           <= 48'd16777216;
            krows_reg[2]           <= 48'd0;
        end
        else
        begin
            geom_reg  <= geom_next;
            krows_reg <= krows_next;
        end
    end

    c2dzp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .KERNEL_MAX (KERNEL_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (work_full),
        .action    (action),
        .pixel     (pixel),
        .geom      (geom_reg),
        .restart   (restart),
        .work_push (work_push),
        .work      (work_in)
    );

    c2dzp_fifo #(
        .W     (WORK_W),
        .DEPTH (c2dzp_pkg::WQ_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .wdata (work_in),
        .full  (work_full),
        .pop   (work_pop),
        .rdata (work_head),
        .empty (work_empty),
        .count (work_count)
    );

    c2dzp_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (work_head),
        .work_empty (work_empty),
        .work_pop   (work_pop),
        .krows      (krows_reg),
        .out_count  (res_count),
        .res_push   (res_push),
        .res        (res_in)
    );

    c2dzp_fifo #(
        .W     (RES_W),
        .DEPTH (c2dzp_pkg::OQ_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head),
        .empty (empty),
        .count (res_count)
    );

    assign full      = work_full;
    assign out_value = res_head.value;
    assign frame_end = res_head.frame_end;

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("Result pushed into a full result queue.");

    a_work_count: assert property (@(posedge clk) disable iff (!rst_n)
        work_pop |-> (work_count != '0))
        else $error("Work record taken from an empty work queue.");

endmodule

/* sim/tb_conv2d_zero_padded_stream.sv */
// Self-checking testbench for conv2d_zero_padded_stream: a scoreboard class predicts each
// convolution result from the accepted pixel stream and checks the popped results in order.
// Depends on c2dzp_pkg and the conv2d_zero_padded_stream RTL.
`timescale 1ns / 100ps

module tb_conv2d_zero_padded_stream;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS = 680;
    localparam int QUIET_AFTER = 580;

    class conv_scoreboard;
        localparam int LINE_LEN = 1024;
        localparam int ROWS_MAX = 4096;
        localparam int KSIZE_MAX = 3;

        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned kw_reg;
        int unsigned kh_reg;
        logic [c2dzp_pkg::KROW_W-1:0] krow [3];
        byte unsigned line_mem [2][LINE_LEN];
        byte unsigned win [3][3];
        int unsigned in_row;
        int unsigned in_col;
        int unsigned out_row;
        int unsigned out_col;
        c2dzp_pkg::result_t expected_q [$];
        int errors;

        function new();
            width_reg = 640;
            height_reg = 480;
            kw_reg = 3;
            kh_reg = 3;
            krow[0] = '0;
            krow[1] = 48'd16777216;
            krow[2] = '0;
            for (int r = 0; r < 2; r++)
                for (int c = 0; c < LINE_LEN; c++)
                    line_mem[r][c] = 0;
            for (int m = 0; m < 3; m++)
                for (int n = 0; n < 3; n++)
                    win[m][n] = 0;
            restart_frame();
            errors = 0;
        endfunction

        function void restart_frame();
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v == 0)
                return 1;
            return (v > hi) ? hi : v;
        endfunction

        function int unsigned cur_w();
            return clamp_size(width_reg, LINE_LEN);
        endfunction

        function int unsigned cur_h();
            return clamp_size(height_reg, ROWS_MAX);
        endfunction

        function int unsigned frame_pixels();
            return cur_w() * cur_h();
        endfunction

        function int unsigned tail_len();
            return (clamp_size(kh_reg, KSIZE_MAX) >> 1) * cur_w()
                + (clamp_size(kw_reg, KSIZE_MAX) >> 1);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int coef(int m, int n);
            logic signed [c2dzp_pkg::COEF_W-1:0] c;
            c = krow[m][16*n +: 16];
            return int'(c);
        endfunction

        function void apply_reg(c2dzp_pkg::reg_idx_t idx,
                                logic [c2dzp_pkg::KROW_W-1:0] data);
            case (idx)
                c2dzp_pkg::REG_IMAGE_WIDTH:
                begin
                    width_reg = data[10:0];
                    restart_frame();
                end
                c2dzp_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_reg = data[12:0];
                    restart_frame();
                end
                c2dzp_pkg::REG_KERNEL_WIDTH:
                begin
                    kw_reg = data[1:0];
                    restart_frame();
                end
                c2dzp_pkg::REG_KERNEL_HEIGHT:
                begin
                    kh_reg = data[1:0];
                    restart_frame();
                end
                c2dzp_pkg::REG_KROW_TOP: krow[0] = data;
                c2dzp_pkg::REG_KROW_MID: krow[1] = data;
                c2dzp_pkg::REG_KROW_BOT: krow[2] = data;
                default: ;
            endcase
        endfunction

        function void note_item(logic act, logic [c2dzp_pkg::PIX_W-1:0] px);
            int unsigned w;
            int unsigned h;
            int unsigned kw;
            int unsigned kh;
            int unsigned cx;
            int unsigned cy;
            int unsigned lag;
            int unsigned pos;
            int unsigned c;
            int tr;
            int tc;
            int sum;
            byte unsigned p;
            bit last;
            c2dzp_pkg::result_t r;
            w = cur_w();
            h = cur_h();
            kw = clamp_size(kw_reg, KSIZE_MAX);
            kh = clamp_size(kh_reg, KSIZE_MAX);
            cx = kw >> 1;
            cy = kh >> 1;
            lag = cy * w + cx;
            if (in_row >= h)
                p = 0;
            else if (!act)
                p = px;
            else
                return;
            pos = in_row * w + in_col;
            c = in_col % LINE_LEN;
            for (int m = 0; m < 3; m++)
            begin
                win[m][2] = win[m][1];
                win[m][1] = win[m][0];
            end
            win[0][0] = p;
            win[1][0] = line_mem[0][c];
            win[2][0] = line_mem[1][c];
            line_mem[1][c] = line_mem[0][c];
            line_mem[0][c] = p;
            if (pos >= lag)
            begin
                sum = 0;
                for (int m = 0; m < kh; m++)
                begin
                    tr = int'(out_row) + int'(cy) - m;
                    if (tr < 0 || tr >= int'(h))
                        continue;
                    for (int n = 0; n < kw; n++)
                    begin
                        tc = int'(out_col) + int'(cx) - n;
                        if (tc < 0 || tc >= int'(w))
                            continue;
                        sum += int'(win[m][n]) * coef(m, n);
                    end
                end
                last = (out_row == h - 1) && (out_col == w - 1);
                r.value = sum[c2dzp_pkg::OUT_W-1:0];
                r.frame_end = last;
                expected_q.insert(expected_q.size(), r);
                if (last)
                begin
                    restart_frame();
                    return;
                end
                out_col++;
                if (out_col >= w)
                begin
                    out_col = 0;
                    out_row++;
                end
            end
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic signed [c2dzp_pkg::OUT_W-1:0] value, logic fend);
            c2dzp_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result value=%0d frame_end=%0b",
                    value, fend));
                return;
            end
            want = expected_q.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("out_value got %0d want %0d", value, want.value));
            if (fend !== want.frame_end)
                report_mismatch($sformatf("frame_end got %0b want %0b", fend,
                    want.frame_end));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic action;
    logic [7:0] pixel;
    logic empty;
    logic pop;
    logic signed [c2dzp_pkg::OUT_W-1:0] out_value;
    logic frame_end;
    logic cfg_valid;
    logic cfg_ready;
    logic [c2dzp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [c2dzp_pkg::KROW_W-1:0] cfg_data;

    conv_scoreboard sb;
    bit quiet;
    int cycle_count;
    int random_count;

    conv2d_zero_padded_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .out_value (out_value),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("conv2d_zero_padded_stream test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_result(out_value, frame_end);
    end

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [c2dzp_pkg::KROW_W-1:0] rand_krow();
        logic [63:0] t;
        t = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return {3{16'h7FFF}};
            1: return {3{16'h8000}};
            default: return t[c2dzp_pkg::KROW_W-1:0];
        endcase
    endfunction

    task send_item(input logic act, input logic [7:0] px);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        action <= act;
        pixel <= px;
        do
            @(posedge clk);
        while (full);
        sb.note_item(act, px);
    endtask

    task settle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task program_reg(input c2dzp_pkg::reg_idx_t idx,
                     input logic [c2dzp_pkg::KROW_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.apply_reg(idx, data);
    endtask

    task release_cfg();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task program_geometry(input int w, input int h, input int kw, input int kh);
        program_reg(c2dzp_pkg::REG_IMAGE_WIDTH, c2dzp_pkg::KROW_W'(w));
        program_reg(c2dzp_pkg::REG_IMAGE_HEIGHT, c2dzp_pkg::KROW_W'(h));
        program_reg(c2dzp_pkg::REG_KERNEL_WIDTH, c2dzp_pkg::KROW_W'(kw));
        program_reg(c2dzp_pkg::REG_KERNEL_HEIGHT, c2dzp_pkg::KROW_W'(kh));
        program_reg(c2dzp_pkg::REG_KROW_TOP, rand_krow());
        program_reg(c2dzp_pkg::REG_KROW_MID, rand_krow());
        program_reg(c2dzp_pkg::REG_KROW_BOT, rand_krow());
        release_cfg();
    endtask

    task run_frame(input bit noisy, input bit truncate);
        int npx;
        int cut;
        npx = sb.frame_pixels();
        cut = truncate ? $urandom_range(0, npx - 1) : npx;
        for (int i = 0; i < cut; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(1'b1, rand_pixel());
            send_item(1'b0, rand_pixel());
            random_count++;
        end
        if (truncate)
            return;
        for (int d = 0; d < sb.tail_len(); d++)
        begin
            if (noisy && $urandom_range(0, 2) == 0)
                send_item(1'b0, rand_pixel());
            else
                send_item(1'b1, rand_pixel());
            random_count++;
        end
        if (noisy)
            repeat ($urandom_range(0, 2)) send_item(1'b1, rand_pixel());
    endtask

    task random_phase();
        int w;
        int nframes;
        case ($urandom_range(0, 4))
            0: w = 1;
            1: w = 2;
            2: w = 3;
            3: w = $urandom_range(4, 12);
            default: w = $urandom_range(1, 6);
        endcase
        program_reg(c2dzp_pkg::REG_IMAGE_WIDTH, c2dzp_pkg::KROW_W'(w));
        if ($urandom_range(0, 1))
            program_reg(c2dzp_pkg::REG_IMAGE_HEIGHT,
                c2dzp_pkg::KROW_W'($urandom_range(0, 5)));
        if ($urandom_range(0, 1))
            program_reg(c2dzp_pkg::REG_KERNEL_WIDTH,
                c2dzp_pkg::KROW_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 1))
            program_reg(c2dzp_pkg::REG_KERNEL_HEIGHT,
                c2dzp_pkg::KROW_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 1))
            program_reg(c2dzp_pkg::REG_KROW_TOP, rand_krow());
        if ($urandom_range(0, 1))
            program_reg(c2dzp_pkg::REG_KROW_MID, rand_krow());
        if ($urandom_range(0, 1))
            program_reg(c2dzp_pkg::REG_KROW_BOT, rand_krow());
        release_cfg();
        nframes = $urandom_range(1, 3);
        for (int f = 0; f < nframes; f++)
            run_frame(1'b1, (f == nframes - 1) && ($urandom_range(0, 5) == 0));
    endtask

    initial
    begin
        sb = new();
        quiet = 1'b0;
        cycle_count = 0;
        random_count = 0;
        rst_n = 1'b0;
        push = 1'b0;
        action = 1'b0;
        pixel = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = c2dzp_pkg::REG_IMAGE_WIDTH;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        settle();
        program_reg(c2dzp_pkg::REG_IMAGE_WIDTH, 48'd3);
        program_reg(c2dzp_pkg::REG_IMAGE_HEIGHT, 48'd2);
        program_reg(c2dzp_pkg::REG_KERNEL_WIDTH, 48'd3);
        program_reg(c2dzp_pkg::REG_KERNEL_HEIGHT, 48'd3);
        program_reg(c2dzp_pkg::REG_KROW_TOP, {16'h8000, 16'h7FFF, 16'h0001});
        program_reg(c2dzp_pkg::REG_KROW_MID, {16'hFFFF, 16'h0100, 16'h8000});
        program_reg(c2dzp_pkg::REG_KROW_BOT, {16'h7FFF, 16'h8000, 16'h0000});
        release_cfg();
        send_item(1'b1, 8'hA5);
        send_item(1'b0, 8'd255);
        send_item(1'b1, 8'd0);
        send_item(1'b0, 8'd0);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd128);
        send_item(1'b0, 8'd1);
        send_item(1'b0, 8'd254);
        send_item(1'b0, 8'd77);
        repeat (3) send_item(1'b1, 8'hFF);
        repeat (2) send_item(1'b1, 8'h00);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd255);
        send_item(1'b0, 8'd255);

        settle();
        program_reg(c2dzp_pkg::REG_IMAGE_WIDTH, 48'd0);
        program_reg(c2dzp_pkg::REG_IMAGE_HEIGHT, 48'd0);
        program_reg(c2dzp_pkg::REG_KERNEL_WIDTH, 48'd0);
        program_reg(c2dzp_pkg::REG_KERNEL_HEIGHT, 48'd0);
        release_cfg();
        send_item(1'b0, 8'd255);
        send_item(1'b1, 8'd255);
        send_item(1'b0, 8'd0);

        settle();
        program_geometry(1024, 2, 3, 1);
        repeat (60) send_item(1'b0, rand_pixel());

        settle();
        program_geometry(1, 4096, 1, 3);
        repeat (60) send_item(1'b0, rand_pixel());

        settle();
        program_geometry(2047, 8191, 2, 2);
        repeat (40) send_item(1'b0, rand_pixel());

        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            settle();
            quiet = (random_count >= QUIET_AFTER);
            random_phase();
        end

        settle();
        if (sb.errors == 0)
            $display("conv2d_zero_padded_stream test passed");
        else
            $display("conv2d_zero_padded_stream test failed");
        $finish;
    end

endmodule
